### hw/rtl/awuq_pkg.sv
package awuq_pkg;

  localparam int unsigned LANES_DEF  = 8;
  localparam int unsigned GRAD_W     = 24;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned WGT_W      = 32;
  localparam int unsigned EPOCH_W    = 32;
  localparam int unsigned QNT_W      = 16;
  localparam int unsigned LANE_W     = 3;
  localparam int unsigned ROOT_W     = 32;
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned ROOT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned APB_ADDR_W = 4;

  localparam logic [23:0] STEP_RST   = 24'd65536;
  localparam logic [31:0] SKIP_RST   = 32'd0;
  localparam logic [23:0] MINSQ_RST  = 24'd6554;

  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_SKIP  = 2'd1;
  localparam logic [1:0] REG_MINSQ = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_CHK,
    ST_ROOT,
    ST_MUL,
    ST_DIV,
    ST_WB,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic sum;
    logic chk;
    logic root_step;
    logic mul;
    logic div_step;
    logic wb;
    logic emit_load;
    logic emit_last;
  } cmd_t;

  typedef struct packed {
    logic upd;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/adagrad_weight_update_quantize.sv
// Per lane item: load, sum and check, then on the update path 32 root steps,
// a multiply and 48 divide steps, then write back; one item in flight at a time.
// After the last lane, LANES results leave one per cycle unless m_axis_tready stalls.
// Throughput is set by the bit-serial square root and restoring divider.
// rst_ni is asynchronous, active low: controller goes idle, config takes defaults.
module adagrad_weight_update_quantize
  import awuq_pkg::*;
#(
  parameter int unsigned LANES = awuq_pkg::LANES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // gradient[23:0], sum_sq[71:24], weight[103:72], epoch[135:104]
  input  logic [IN_DATA_W-1:0]        s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // lane[2:0], new_weight[34:3], new_sum_sq[82:35], quantized[98:83], zero fill
  output logic [OUT_DATA_W-1:0]       m_axis_tdata,
  // write_entry[0]
  output logic                        m_axis_tuser,
  output logic                        m_axis_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [APB_ADDR_W-1:0]       paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int unsigned IDX_W = (LANES > 1) ? $clog2(LANES) : 1;

  logic [23:0] step_q;
  logic [31:0] skip_q;
  logic [23:0] minsq_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= STEP_RST;
      skip_q  <= SKIP_RST;
      minsq_q <= MINSQ_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_STEP:  step_q  <= pwdata[23:0];
        REG_SKIP:  skip_q  <= pwdata;
        REG_MINSQ: minsq_q <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_STEP:  prdata = {8'b0, step_q};
      REG_SKIP:  prdata = skip_q;
      REG_MINSQ: prdata = {8'b0, minsq_q};
      default:   prdata = '0;
    endcase
  end

  cmd_t             cmd;
  sts_t             sts;
  logic [IDX_W-1:0] lane_idx, emit_idx;
  logic [2:0]       o_lane;
  logic [31:0]      o_w;
  logic [47:0]      o_s;
  logic [15:0]      o_q;

  awuq_ctrl #(.LANES(LANES), .IDX_W(IDX_W)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .lane_o     (lane_idx),
    .emit_o     (emit_idx)
  );

  awuq_dp #(.LANES(LANES), .IDX_W(IDX_W)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .lane_i        (lane_idx),
    .emit_i        (emit_idx),
    .step_size_i   (step_q),
    .skip_epochs_i (skip_q),
    .min_sum_sq_i  (minsq_q),
    .gradient_i    (s_axis_tdata[23:0]),
    .sum_sq_i      (s_axis_tdata[71:24]),
    .weight_i      (s_axis_tdata[103:72]),
    .epoch_i       (s_axis_tdata[135:104]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .lane_o        (o_lane),
    .new_weight_o  (o_w),
    .new_sum_sq_o  (o_s),
    .quantized_o   (o_q),
    .write_entry_o (m_axis_tuser),
    .last_o        (m_axis_tlast)
  );

  assign m_axis_tdata = {5'b0, o_q, o_s, o_w, o_lane};

endmodule

### hw/rtl/awuq_ctrl.sv
module awuq_ctrl #(
  parameter int unsigned LANES = awuq_pkg::LANES_DEF,
  parameter int unsigned IDX_W = 3
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  awuq_pkg::sts_t    sts_i,
  output awuq_pkg::cmd_t    cmd_o,
  output logic [IDX_W-1:0]  lane_o,
  output logic [IDX_W-1:0]  emit_o
);
  import awuq_pkg::*;

  localparam logic [IDX_W-1:0] LAST_LANE = IDX_W'(LANES - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] lane_q, lane_d;
  logic [IDX_W-1:0] emit_q, emit_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      lane_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      lane_q  <= lane_d;
      emit_q  <= emit_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    lane_d  = lane_q;
    emit_d  = emit_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SUM;
      ST_SUM:  state_d = ST_CHK;
      ST_CHK: begin
        cnt_d   = '0;
        state_d = sts_i.upd ? ST_ROOT : ST_WB;
      end
      ST_ROOT: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_STEPS - 1)) state_d = ST_MUL;
      end
      ST_MUL: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_WB;
      end
      ST_WB: begin
        emit_d = '0;
        if (lane_q == LAST_LANE) begin
          state_d = ST_EMIT;
        end else begin
          lane_d  = lane_q + 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          emit_d = emit_q + 1'b1;
          if (emit_q == LAST_LANE) begin
            lane_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SUM:  cmd_o.sum       = 1'b1;
      ST_CHK:  cmd_o.chk       = 1'b1;
      ST_ROOT: cmd_o.root_step = 1'b1;
      ST_MUL:  cmd_o.mul       = 1'b1;
      ST_DIV:  cmd_o.div_step  = 1'b1;
      ST_WB:   cmd_o.wb        = 1'b1;
      ST_EMIT: begin
        cmd_o.emit_load = sts_i.out_free;
        cmd_o.emit_last = sts_i.out_free && (emit_q == LAST_LANE);
      end
      default: cmd_o = '0;
    endcase
  end

  assign lane_o = lane_q;
  assign emit_o = emit_q;

endmodule

### hw/rtl/awuq_dp.sv
module awuq_dp #(
  parameter int unsigned LANES = awuq_pkg::LANES_DEF,
  parameter int unsigned IDX_W = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  awuq_pkg::cmd_t                cmd_i,
  output awuq_pkg::sts_t                sts_o,
  input  logic [IDX_W-1:0]              lane_i,
  input  logic [IDX_W-1:0]              emit_i,
  input  logic [23:0]                   step_size_i,
  input  logic [31:0]                   skip_epochs_i,
  input  logic [23:0]                   min_sum_sq_i,
  input  logic signed [23:0]            gradient_i,
  input  logic [47:0]                   sum_sq_i,
  input  logic signed [31:0]            weight_i,
  input  logic [31:0]                   epoch_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [2:0]                    lane_o,
  output logic signed [31:0]            new_weight_o,
  output logic [47:0]                   new_sum_sq_o,
  output logic signed [15:0]            quantized_o,
  output logic                          write_entry_o,
  output logic                          last_o
);
  import awuq_pkg::*;

  localparam logic signed [31:0] W_HI = 32'sd1073709056;   // 32767 << 15
  localparam logic signed [31:0] W_LO = -32'sd1073741824;  // -32768 << 15

  logic signed [23:0] g_q;
  logic [47:0]        s_q;
  logic signed [31:0] w_q;
  logic               skip_q, upd_q, any_q;
  logic [63:0]        rad_q;
  logic [34:0]        rem_q;
  logic [31:0]        root_q;
  logic [47:0]        dvd_q;
  logic [33:0]        drem_q;
  logic [32:0]        dvs_q;

  logic signed [31:0] wbuf [LANES];
  logic [47:0]        sbuf [LANES];

  logic               ov_q;
  logic [2:0]         ol_q;
  logic signed [31:0] ow_q;
  logic [47:0]        os_q;
  logic signed [15:0] oq_q;
  logic               oe_q, olast_q;

  logic [23:0] ag;
  logic [47:0] sq_full;
  logic [32:0] sq;
  logic [48:0] sum_ext;
  logic [34:0] rrem, rtrial;
  logic [31:0] rr;
  logic [47:0] num;
  logic [33:0] drem2;
  logic        dge;
  logic signed [49:0] wext, dext, wres;
  logic signed [31:0] wsat;
  logic signed [31:0] wk, wc;
  logic [31:0] mag;
  logic [16:0] qmag;
  logic signed [15:0] qv;

  assign ag      = g_q[23] ? 24'(-g_q) : 24'(g_q);
  assign sq_full = ag * ag;
  assign sq      = 33'((49'(sq_full) + 49'h8000) >> 16);
  assign sum_ext = {1'b0, s_q} + {16'b0, sq};

  assign rrem   = {rem_q[32:0], rad_q[63:62]};
  assign rtrial = {1'b0, root_q, 2'b01};

  assign rr  = (root_q == '0) ? 32'd1 : root_q;
  assign num = step_size_i * ag;

  assign drem2 = {drem_q[32:0], dvd_q[47]};
  assign dge   = drem2 >= {1'b0, dvs_q};

  assign wext = 50'(w_q);
  assign dext = $signed({2'b0, dvd_q});
  assign wres = (!g_q[23]) ? (wext - dext) : (wext + dext);
  always_comb begin
    if (wres > 50'sd2147483647)       wsat = 32'sh7fffffff;
    else if (wres < -50'sd2147483648) wsat = 32'sh80000000;
    else                              wsat = wres[31:0];
  end

  assign sts_o.upd      = (g_q != '0) && !skip_q && (s_q >= {24'b0, min_sum_sq_i});
  assign sts_o.out_free = !ov_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      g_q    <= gradient_i;
      s_q    <= sum_sq_i;
      w_q    <= weight_i;
      skip_q <= epoch_i <= skip_epochs_i;
    end
    if (cmd_i.sum && g_q != '0) begin
      s_q <= sum_ext[48] ? '1 : sum_ext[47:0];
    end
    if (cmd_i.chk) begin
      upd_q  <= sts_o.upd;
      rad_q  <= {s_q, 16'b0};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root_step) begin
      rad_q <= {rad_q[61:0], 2'b00};
      if (rrem >= rtrial) begin
        rem_q  <= rrem - rtrial;
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rrem;
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.mul) begin
      dvd_q  <= num + {16'b0, rr};
      dvs_q  <= {rr, 1'b0};
      drem_q <= '0;
    end
    if (cmd_i.div_step) begin
      dvd_q  <= {dvd_q[46:0], dge};
      drem_q <= dge ? (drem2 - {1'b0, dvs_q}) : drem2;
    end
    if (cmd_i.wb) begin
      wbuf[lane_i] <= upd_q ? wsat : w_q;
      sbuf[lane_i] <= s_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q <= 1'b0;
    end else if (cmd_i.emit_last) begin
      any_q <= 1'b0;
    end else if (cmd_i.wb && upd_q) begin
      any_q <= 1'b1;
    end
  end

  // clamp and round half away from zero
  assign wk   = wbuf[emit_i];
  assign wc   = (wk > W_HI) ? W_HI : ((wk < W_LO) ? W_LO : wk);
  assign mag  = wc[31] ? 32'(-wc) : 32'(wc);
  assign qmag = 17'((mag + 32'h4000) >> 15);
  assign qv   = wc[31] ? 16'(-qmag) : 16'(qmag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      ol_q    <= 3'(emit_i);
      ow_q    <= any_q ? wc : wk;
      os_q    <= sbuf[emit_i];
      oq_q    <= any_q ? qv : '0;
      oe_q    <= any_q;
      olast_q <= cmd_i.emit_last;
    end
  end

  assign out_valid_o   = ov_q;
  assign lane_o        = ol_q;
  assign new_weight_o  = ow_q;
  assign new_sum_sq_o  = os_q;
  assign quantized_o   = oq_q;
  assign write_entry_o = oe_q;
  assign last_o        = olast_q;

endmodule

### hw/rtl/awuq_checker.sv
module awuq_checker #(
  parameter int unsigned LANES = awuq_pkg::LANES_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata,
  input logic         m_axis_tuser,
  input logic         m_axis_tlast
);

  localparam logic [2:0] LAST_LANE = 3'((LANES - 1) % 8);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_last_lane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[2:0] == LAST_LANE)
    else $error("last flag on wrong lane");

  a_no_write_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[98:83] == 16'd0)
    else $error("quantized value without entry write");

endmodule

bind adagrad_weight_update_quantize awuq_checker #(.LANES(LANES)) u_awuq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/tb_adagrad_weight_update_quantize.sv
`timescale 1ns / 100ps

module tb_adagrad_weight_update_quantize;
  import awuq_pkg::*;

  localparam int unsigned NL = 8;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  lane;
    logic [31:0] new_weight;
    logic [47:0] new_sum_sq;
    logic [15:0] quantized;
    logic        write_entry;
    logic        last;
  } lane_result_t;

  // AdaGrad predictor: own copy of the registers and lane buffers
  class adagrad_scoreboard;
    logic [23:0] step_size;
    logic [31:0] skip_epochs;
    logic [23:0] min_sum_sq;
    int unsigned lane_count;
    logic [31:0] wbuf[NL];
    logic [47:0] sbuf[NL];
    bit          any_upd;
    lane_result_t pending[$];
    int unsigned  errors;

    function new();
      step_size = STEP_RST;
      skip_epochs = SKIP_RST;
      min_sum_sq = MINSQ_RST;
      lane_count = 0;
      any_upd = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_STEP:  step_size = val[23:0];
        REG_SKIP:  skip_epochs = val;
        REG_MINSQ: min_sum_sq = val[23:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function void note_lane(logic [23:0] grad, logic [47:0] sum, logic [31:0] wgt,
                            logic [31:0] epoch);
      longint g, w, wk, q;
      logic [63:0] ag, sq, s, r, num, d, mag;
      lane_result_t res;
      g = longint'(signed'(grad));
      w = longint'(signed'(wgt));
      s = {16'd0, sum};
      if (g != 0) begin
        ag = (g < 0) ? -g : g;
        sq = (ag * ag + 64'h8000) >> 16;
        s = (s > 64'hFFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF : s + sq;
        if (!(epoch <= skip_epochs) && s >= {40'd0, min_sum_sq}) begin
          r = root64(s << 16);
          if (r == 0) r = 1;
          num = {40'd0, step_size} * ag;
          d = (num + r) / (2 * r);
          w = (g > 0) ? w - longint'(d) : w + longint'(d);
          if (w > 64'sd2147483647) w = 64'sd2147483647;
          if (w < -64'sd2147483648) w = -64'sd2147483648;
          any_upd = 1;
        end
      end
      wbuf[lane_count] = w[31:0];
      sbuf[lane_count] = s[47:0];
      if (lane_count + 1 < NL) begin
        lane_count++;
        return;
      end
      for (int k = 0; k < NL; k++) begin
        wk = longint'(signed'(wbuf[k]));
        q = 0;
        if (any_upd) begin
          if (wk > 32767 * 32768) wk = 32767 * 32768;
          if (wk < -32768 * 32768) wk = -32768 * 32768;
          mag = (wk < 0) ? -wk : wk;
          mag = (mag + 64'h4000) >> 15;
          q = (wk < 0) ? -longint'(mag) : longint'(mag);
        end
        res.lane = k[2:0];
        res.new_weight = wk[31:0];
        res.new_sum_sq = sbuf[k];
        res.quantized = q[15:0];
        res.write_entry = any_upd;
        res.last = (k == NL - 1);
        pending.push_back(res);
      end
      lane_count = 0;
      any_upd = 0;
    endfunction

    function void check_result(lane_result_t got);
      lane_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result transaction lane=%0d", got.lane);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.lane !== exp_r.lane) begin
        $error("lane: expected %0d, got %0d", exp_r.lane, got.lane); errors++;
      end
      if (got.new_weight !== exp_r.new_weight) begin
        $error("new_weight: expected %h, got %h", exp_r.new_weight, got.new_weight);
        errors++;
      end
      if (got.new_sum_sq !== exp_r.new_sum_sq) begin
        $error("new_sum_sq: expected %h, got %h", exp_r.new_sum_sq, got.new_sum_sq);
        errors++;
      end
      if (got.quantized !== exp_r.quantized) begin
        $error("quantized: expected %h, got %h", exp_r.quantized, got.quantized);
        errors++;
      end
      if (got.write_entry !== exp_r.write_entry) begin
        $error("write_entry: expected %0b, got %0b", exp_r.write_entry, got.write_entry);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0b, got %0b", exp_r.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tuser, m_axis_tlast;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  adagrad_weight_update_quantize dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  adagrad_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;

  // output side: random stall, check at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    lane_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.lane = m_axis_tdata[2:0];
      got.new_weight = m_axis_tdata[34:3];
      got.new_sum_sq = m_axis_tdata[82:35];
      got.quantized = m_axis_tdata[98:83];
      got.write_entry = m_axis_tuser;
      got.last = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= APB_ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  task automatic send_lane(logic [23:0] g, logic [47:0] s, logic [31:0] w, logic [31:0] e);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {e, w, s, g};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_lane(g, s, w, e);
    @(negedge clk_i);
    s_axis_tvalid <= 0;
  endtask

  // wait for all results, then let an in-flight lane finish
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic random_entry();
    logic [23:0] g;
    logic [47:0] s;
    logic [31:0] w, e;
    int unsigned kind;
    for (int k = 0; k < NL; k++) begin
      kind = $urandom_range(9);
      g = (kind == 0) ? 24'd0 : (kind < 4) ? 24'($urandom) :
          24'(int'($urandom_range(8192)) - 4096);
      s = (kind == 5) ? 48'({$urandom, $urandom}) :
          (kind == 6) ? 48'hFFFF_FFFF_FFFF - 48'($urandom_range(1000)) :
          48'($urandom_range(1 << 20));
      w = (kind == 7) ? $urandom : 32'(int'($urandom_range(1 << 22)) - (1 << 21));
      e = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(8));
      send_lane(g, s, w, e);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;

    // directed: extremes, zero gradient, zero root, skipped epochs
    send_lane(24'h7FFFFF, 48'd0, 32'h7FFF_FFFF, 32'd5);
    send_lane(24'h800000, 48'hFFFF_FFFF_FFFF, 32'h8000_0000, 32'd5);
    send_lane(24'd0, 48'd123, 32'd4000, 32'd5);
    send_lane(24'd1, 48'd0, 32'hFFFF_C000, 32'hFFFF_FFFF);
    send_lane(24'hFFFFFF, 48'd10, 32'd16384, 32'd1);
    send_lane(24'd65536, 48'd65536, 32'h3FFF_FFFF, 32'd2);
    send_lane(24'h400000, 48'h8000_0000_0000, 32'hC000_0000, 32'd3);
    send_lane(24'd100, 48'd1000, 32'd49152, 32'd0);
    // entry with nothing updated: zero gradients only
    for (int k = 0; k < NL; k++) send_lane(24'd0, 48'(k), 32'($urandom), 32'd9);
    drain();
    apb_write(REG_MINSQ, 32'd0);
    apb_write(REG_STEP, 32'hFFFFFF);
    apb_write(REG_SKIP, 32'd4);
    send_lane(24'd1, 48'd0, 32'd0, 32'd9);
    send_lane(24'hFFFFFF, 48'd0, 32'h7FFF_0000, 32'd9);
    send_lane(24'h7FFFFF, 48'd0, 32'h8000_0000, 32'd9);
    send_lane(24'd5, 48'd7, 32'd100, 32'd4);
    for (int k = 0; k < 4; k++) send_lane(24'd0, 48'd0, 32'd16383, 32'd9);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 73; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 73; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      apb_write(REG_STEP, (ph == 0) ? 32'd0 : 32'($urandom_range(24'hFFFFFF)));
      apb_write(REG_SKIP, (ph == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(4)));
      apb_write(REG_MINSQ, (ph == 2) ? 32'hFFFFFF : 32'($urandom_range(20000)));
      for (int n = 0; n < 10; n++) random_entry();
      drain();
    end

    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### adagrad_weight_update_quantize.f
hw/rtl/awuq_pkg.sv
hw/rtl/awuq_ctrl.sv
hw/rtl/awuq_dp.sv
hw/rtl/adagrad_weight_update_quantize.sv
hw/rtl/awuq_checker.sv
tb/tb_adagrad_weight_update_quantize.sv
